// ----- hw/rtl/bble_pkg.sv -----
// Shared types and constants for the byte-budgeted LRU evictor.
package bble_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int SLOT_W       = 4;
    localparam int DIM_W        = 14;
    localparam int BPP_W        = 6;
    localparam int STAMP_W      = 48;
    localparam int BYTES_W      = 31;
    localparam int TOTAL_W      = 36;
    localparam int COUNT_W      = 5;
    // Wide enough for any raw slot byte sum and for the budget.
    localparam int TOTAL_CMP_W  = 37;

    localparam int IN_TDATA_W   = 88;
    localparam int OUT_TDATA_W  = 48;

    localparam logic [TOTAL_W-1:0] MAX_BYTES_RESET = 36'd1073741824;

    // Request kinds and result kinds.
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PEEK    = 1'b1;
    localparam logic RESULT_EVICT = 1'b0;
    localparam logic RESULT_STAT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_WRITE,
        ST_CHECK,
        ST_SCAN,
        ST_EVICT,
        ST_STATUS
    } bble_state_t;

endpackage

// ----- hw/rtl/byte_budget_lru_evictor.sv -----
// Top level of the byte-budgeted LRU evictor: slot memories, scan engine and stream ports.
//
// The block keeps a table of SLOTS cache slots. A load request (tuser 0) on a
// slot that already holds data only refreshes its last-use stamp; otherwise the
// slot gets width*height*depth/8 bytes, is marked complete and stamped, and then
// the least recently used slots with nonzero bytes are unloaded one at a time
// until the raw byte total no longer exceeds the budget written on the cfg
// channel. Each unload gives one result beat (tuser 0), and every request ends
// with one status beat (tuser 1, tlast 1) that carries the requested slot, the
// was-loaded flag, the saturated byte total and the count of complete slots.
// A peek (tuser 1 on input) refreshes the stamp of a loaded slot and only gives
// the status beat. Slot numbers at or above SLOTS are ignored apart from their
// status beat. The block takes one request at a time. A peek or a hit passes
// through the decide and status states; a load passes through the decide,
// multiply, write and check states before the status state. Every unload
// adds a scan that reads one entry per cycle from the single read port of
// the stamp and byte memories and then finishes its last compare, followed
// by the eviction step and another budget check. The next request can be
// accepted in the cycle after its status beat is loaded into the output
// register, and results only wait on m_axis_tready while the output
// register is still full. Stamps and byte sizes live in two synchronous
// memories; loaded, complete and nonzero-byte flags are flip-flops cleared
// by reset, so no memory clearing pass is needed. The budget register can
// be written at any time and resets to 1 GiB.
module byte_budget_lru_evictor #(
    parameter int SLOTS = bble_pkg::SLOTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: slot[3:0], image_width[17:4], image_height[31:18],
    //        bits_per_pixel[37:32], now_ms[85:38], zero[87:86]
    input  logic [bble_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: kind[0]
    input  logic                                s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: result_slot[3:0], was_loaded[4], total_bytes[40:5],
    //        complete_count[45:41], zero[47:46]
    output logic [bble_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: result_kind[0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    // Budget register write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bble_pkg::TOTAL_W-1:0]        cfg_data
);
    import bble_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int RAW_W = BYTES_W + IDX_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    bble_state_t state_reg, state_next;

    logic [TOTAL_W-1:0]  max_reg;

    logic                kind_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [BPP_W-1:0]    bpp_reg;
    logic [STAMP_W-1:0]  now_reg;
    logic                wl_reg, wl_next;

    logic [2*DIM_W-1:0]       prod_a_reg;
    logic [2*DIM_W+BPP_W-1:0] prod_b_reg;

    logic [SLOTS-1:0]    has_data_reg, has_data_next;
    logic [SLOTS-1:0]    complete_reg, complete_next;
    logic [SLOTS-1:0]    nz_reg, nz_next;
    logic [RAW_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [CNT_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0]  best_stamp_reg, best_stamp_next;
    logic [BYTES_W-1:0]  best_bytes_reg, best_bytes_next;

    logic                m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                m_user_reg;
    logic                m_last_reg;

    // ------------------------------------------------------------------
    // Slot memories: one write port, one registered read port each.
    // ------------------------------------------------------------------
    logic [STAMP_W-1:0]  stamp_mem [SLOTS];
    logic [BYTES_W-1:0]  bytes_mem [SLOTS];
    logic [STAMP_W-1:0]  stamp_rd_reg;
    logic [BYTES_W-1:0]  bytes_rd_reg;

    logic                we_stamp;
    logic                we_bytes;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic [BYTES_W-1:0]  new_bytes;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic                s_accept;
    logic                can_emit;
    logic                slot_in_range;
    logic [IDX_W-1:0]    slot_idx;
    logic                scan_issue;
    logic                over_budget;
    logic [RAW_W-1:0]    total_evicted;
    logic [RAW_W-1:0]    total_sel;
    logic [CNT_W-1:0]    cnt_sel;
    logic [TOTAL_CMP_W-1:0] total_wide;
    logic [TOTAL_W-1:0]  total_sat;

    logic                emit;
    logic                emit_kind;
    logic [SLOT_W-1:0]   emit_slot;
    logic                emit_last;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign can_emit      = !m_valid_reg || m_axis_tready;

    assign slot_in_range = ({3'b000, slot_reg} < 7'(SLOTS));
    assign slot_idx      = IDX_W'(slot_reg);
    assign scan_issue    = (scan_cnt_reg < CNT_W'(SLOTS));
    assign rd_addr       = scan_issue ? scan_cnt_reg[IDX_W-1:0] : '0;
    assign new_bytes     = prod_b_reg[2*DIM_W+BPP_W-1:3];
    assign over_budget   = (TOTAL_CMP_W'(total_reg) > TOTAL_CMP_W'(max_reg));
    assign total_evicted = total_reg - RAW_W'(best_bytes_reg);

    // Status and eviction beats report the totals after their own action.
    assign total_sel  = (state_reg == ST_EVICT) ? total_evicted : total_reg;
    assign cnt_sel    = (state_reg == ST_EVICT) ? (cnt_reg - CNT_W'(1)) : cnt_reg;
    assign total_wide = TOTAL_CMP_W'(total_sel);
    assign total_sat  = (total_wide > TOTAL_CMP_W'({TOTAL_W{1'b1}})) ?
                        {TOTAL_W{1'b1}} : total_wide[TOTAL_W-1:0];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!slot_in_range || kind_reg == KIND_PEEK || has_data_reg[slot_idx])
                begin
                    state_next = ST_STATUS;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (over_budget && (nz_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_SCAN:
            begin
                if (!scan_issue && !cmp_vld_reg)
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                if (can_emit)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_STATUS:
            begin
                if (can_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs per state
    // ------------------------------------------------------------------
    always_comb
    begin
        we_stamp        = 1'b0;
        we_bytes        = 1'b0;
        wr_addr         = slot_idx;
        wl_next         = wl_reg;
        has_data_next   = has_data_reg;
        complete_next   = complete_reg;
        nz_next         = nz_reg;
        total_next      = total_reg;
        cnt_next        = cnt_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        best_bytes_next = best_bytes_reg;
        emit            = 1'b0;
        emit_kind       = RESULT_STAT;
        emit_slot       = slot_reg;
        emit_last       = 1'b1;

        case (state_reg)
            ST_DECIDE:
            begin
                if (slot_in_range)
                begin
                    wl_next = has_data_reg[slot_idx];
                    // A peek or a hit on a loaded slot only refreshes its stamp.
                    we_stamp = has_data_reg[slot_idx];
                end
                else
                begin
                    wl_next = 1'b0;
                end
            end
            ST_WRITE:
            begin
                we_stamp = 1'b1;
                we_bytes = 1'b1;
                // A failed load has a zero dimension, so its product is zero too.
                has_data_next[slot_idx] = (width_reg != '0) && (height_reg != '0);
                nz_next[slot_idx]       = (new_bytes != '0);
                complete_next[slot_idx] = 1'b1;
                if (!complete_reg[slot_idx])
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                // The slot held no data, so its old byte count was zero.
                total_next = total_reg + RAW_W'(new_bytes);
            end
            ST_CHECK:
            begin
                scan_cnt_next = '0;
                best_vld_next = 1'b0;
            end
            ST_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = rd_addr;
                end
                // Ascending scan with a strict compare keeps the lowest slot on ties.
                if (cmp_vld_reg && nz_reg[cmp_idx_reg] &&
                    (!best_vld_reg || stamp_rd_reg < best_stamp_reg))
                begin
                    best_vld_next   = 1'b1;
                    best_idx_next   = cmp_idx_reg;
                    best_stamp_next = stamp_rd_reg;
                    best_bytes_next = bytes_rd_reg;
                end
            end
            ST_EVICT:
            begin
                emit_kind = RESULT_EVICT;
                emit_slot = SLOT_W'(best_idx_reg);
                emit_last = 1'b0;
                if (can_emit)
                begin
                    emit = 1'b1;
                    has_data_next[best_idx_reg] = 1'b0;
                    complete_next[best_idx_reg] = 1'b0;
                    nz_next[best_idx_reg]       = 1'b0;
                    total_next = total_evicted;
                    cnt_next   = cnt_reg - CNT_W'(1);
                end
            end
            ST_STATUS:
            begin
                emit = can_emit;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            max_reg      <= MAX_BYTES_RESET;
            has_data_reg <= '0;
            complete_reg <= '0;
            nz_reg       <= '0;
            total_reg    <= '0;
            cnt_reg      <= '0;
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            has_data_reg <= has_data_next;
            complete_reg <= complete_next;
            nz_reg       <= nz_next;
            total_reg    <= total_next;
            cnt_reg      <= cnt_next;
            scan_cnt_reg <= scan_cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            best_vld_reg <= best_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                max_reg <= cfg_data;
            end
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kind_reg   <= s_axis_tuser;
            slot_reg   <= s_axis_tdata[3:0];
            width_reg  <= s_axis_tdata[17:4];
            height_reg <= s_axis_tdata[31:18];
            bpp_reg    <= s_axis_tdata[37:32];
            now_reg    <= s_axis_tdata[85:38];
        end
        wl_reg          <= wl_next;
        prod_a_reg      <= width_reg * height_reg;
        prod_b_reg      <= prod_a_reg * bpp_reg;
        cmp_idx_reg     <= cmp_idx_next;
        best_idx_reg    <= best_idx_next;
        best_stamp_reg  <= best_stamp_next;
        best_bytes_reg  <= best_bytes_next;
        if (emit)
        begin
            m_data_reg <= {2'b00, COUNT_W'(cnt_sel), total_sat, wl_reg, emit_slot};
            m_user_reg <= emit_kind;
            m_last_reg <= emit_last;
        end
    end

    // Writes and scan reads never share a cycle: the sequencer finishes every
    // write before the scan starts, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (we_stamp)
        begin
            stamp_mem[wr_addr] <= now_reg;
        end
        if (we_bytes)
        begin
            bytes_mem[wr_addr] <= new_bytes;
        end
        stamp_rd_reg <= stamp_mem[rd_addr];
        bytes_rd_reg <= bytes_mem[rd_addr];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) == $countones(complete_reg))
        else $error("complete count disagrees with complete flags");

    a_nonzero_is_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (nz_reg & ~(has_data_reg & complete_reg)) == '0)
        else $error("slot with bytes is not loaded and complete");

    a_empty_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (nz_reg == '0) |-> (total_reg == '0))
        else $error("byte total nonzero with no slot holding bytes");

    a_evict_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVICT) |-> (best_vld_reg && nz_reg[best_idx_reg]))
        else $error("eviction without a valid victim");

    a_accept_starts_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_DECIDE))
        else $error("accepted request did not start processing");

endmodule
